// ===== design/tta_pkg.sv =====
// Shared types, operation codes and saturation helpers for the tangent accumulator.
`default_nettype none
package tta_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_READ     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GEO_B,
    S_GEO_C,
    S_DIFF,
    S_DET_M1,
    S_DET_M2,
    S_DET,
    S_F_INIT,
    S_F_DIV,
    S_IN_M1,
    S_IN_M2,
    S_IN_SUB,
    S_T_MUL,
    S_T_SAT,
    S_TAN_RD,
    S_TAN_WR,
    S_RD_DATA,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_SUM,
    S_CHK,
    S_SQRT,
    S_N_INIT,
    S_N_DIV,
    S_RD_OUT
  } state_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturated b - a.
  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] b,
                                                 input logic signed [31:0] a);
    logic signed [63:0] d;
    d = 64'(b) - 64'(a);
    return sat32(d);
  endfunction

  // Saturated a + b.
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] d;
    d = 64'(a) + 64'(b);
    return sat32(d);
  endfunction

  // Apply the sign to an unsigned quotient and clamp to 32 bits.
  function automatic logic signed [31:0] quo_sat(input logic [63:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (q > 64'h80000000) ? 32'sh80000000 : 32'(32'd0 - q[31:0]);
    end else begin
      r = (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/tta_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/triangle_tangent_accumulate.sv =====
// Top level of the per-vertex tangent accumulator: sequencer, shared arithmetic, stores.
//
//   channel | direction | handshake                     | word
//   item    | in        | item_valid / item_stall       | operation, indexes, position, uv
//   result  | out       | result_valid / result_stall   | vertex index, tangent, normalized
//
// A triangle runs through the bit-serial divider for f (FRAC_BITS + 33 quotient
// bits) and a read-modify-write of each corner through the single tangent memory
// port; a zero denominator skips the divider.
// A read takes a bit-serial square root of 32 result bits and three divisions of
// FRAC_BITS + 33 quotient bits each through the shared divider. A short tangent
// skips both. Either read waits in its final step while the result register is
// still held by a stalled word.
// Reset clears only the sequencer and the result valid flag; the stores are undefined
// until loaded. A stalled result is held in its output register while the next word
// may already be taken and worked on; only the final step of a read waits for it.
`default_nettype none
module triangle_tangent_accumulate #(
  parameter int MAX_VERTICES = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  wire  [1:0]         operation,
  input  wire  [9:0]         vtx_index,
  input  wire  signed [31:0] pos_x,
  input  wire  signed [31:0] pos_y,
  input  wire  signed [31:0] pos_z,
  input  wire  signed [31:0] tex_u,
  input  wire  signed [31:0] tex_v,
  input  wire  [9:0]         corner_a,
  input  wire  [9:0]         corner_b,
  input  wire  [9:0]         corner_c,
  output logic               result_valid,
  input  wire                result_stall,
  output logic [9:0]         out_vtx_index,
  output logic signed [31:0] tangent_x,
  output logic signed [31:0] tangent_y,
  output logic signed [31:0] tangent_z,
  output logic               normalized
);
  import tta_pkg::*;

  localparam int AW        = $clog2(MAX_VERTICES);
  localparam int DIV_STEPS = FRAC_BITS + 33;
  localparam int CW        = $clog2(DIV_STEPS);
  localparam int NUM_SHIFT = 64 - DIV_STEPS;
  localparam logic [63:0] THRESH = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

  state_t state, state_next;

  // Memory ports.
  logic          geo_we;
  logic [AW-1:0] geo_waddr, geo_raddr;
  logic [159:0]  geo_wdata, geo_rdata;
  logic          tan_we;
  logic [AW-1:0] tan_waddr, tan_raddr;
  logic [95:0]   tan_wdata, tan_rdata;

  // Captured word.
  logic [9:0]    vi;
  logic [AW-1:0] ra, rb, rc;

  // Triangle datapath.
  logic [159:0]       geo_a, geo_b;
  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] du1, dv1, du2, dv2;
  logic signed [63:0] hold, det;
  logic signed [31:0] f;
  logic signed [31:0] inner [3];
  logic signed [31:0] tv [3];
  logic [1:0]         ax;
  logic [AW-1:0]      corner_sel;

  // Shared multiplier.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_w, mul_p, mul_fs;

  // Read datapath.
  logic signed [31:0] tn [3];
  logic signed [31:0] nrm [3];
  logic               norm_flag;
  logic [63:0]        sos;
  logic [63:0]        sq_n, sq_res, sq_bit, sq_try;
  logic               sq_ge;

  // Shared divider.
  logic [63:0]        dv_num, dv_den, dv_rem, dv_q, dv_rem_nx, dv_q_nx;
  logic [64:0]        dv_sh;
  logic               dv_neg, dv_ge, dv_last;
  logic [CW-1:0]      dv_cnt;
  logic signed [31:0] dv_res;

  logic               accept, vi_ok, tri_ok, out_room;
  logic signed [63:0] den_w;
  logic [63:0]        den_mag;
  logic signed [31:0] tn_sel;
  logic [32:0]        c_mag;

  assign accept   = item_valid && !item_stall;
  assign vi_ok    = 32'(vtx_index) < MAX_VERTICES;
  assign tri_ok   = (32'(corner_a) < MAX_VERTICES) && (32'(corner_b) < MAX_VERTICES)
                 && (32'(corner_c) < MAX_VERTICES);
  assign out_room = !result_valid || !result_stall;

  assign geo_wdata = {pos_x, pos_y, pos_z, tex_u, tex_v};

  tta_ram #(.WIDTH(160), .DEPTH(MAX_VERTICES)) u_geo_ram (
    .clk  (clk),
    .we   (geo_we),
    .waddr(geo_waddr),
    .wdata(geo_wdata),
    .raddr(geo_raddr),
    .rdata(geo_rdata)
  );

  tta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_tan_ram (
    .clk  (clk),
    .we   (tan_we),
    .waddr(tan_waddr),
    .wdata(tan_wdata),
    .raddr(tan_raddr),
    .rdata(tan_rdata)
  );

  // Multiplier operands come from the sequencer; the product is always registered,
  // so every consumer works on the product of the previous state.
  assign mul_w  = mul_a * mul_b;
  assign mul_fs = mul_p >>> FRAC_BITS;

  always_comb begin
    case (ax)
      2'd0:    corner_sel = ra;
      2'd1:    corner_sel = rb;
      default: corner_sel = rc;
    endcase
  end

  // Square-root step: one result bit per cycle.
  assign sq_try = sq_res + sq_bit;
  assign sq_ge  = sq_n >= sq_try;

  // Restoring divider step: one quotient bit per cycle.
  assign dv_sh     = {dv_rem, dv_num[63]};
  assign dv_ge     = dv_sh >= {1'b0, dv_den};
  assign dv_rem_nx = dv_ge ? 64'(dv_sh - {1'b0, dv_den}) : dv_sh[63:0];
  assign dv_q_nx   = {dv_q[62:0], dv_ge};
  assign dv_res    = quo_sat(dv_q_nx, dv_neg);
  assign dv_last   = dv_cnt == CW'(DIV_STEPS - 1);

  assign den_w   = det + 64'sd1;
  assign den_mag = den_w[63] ? 64'(-den_w) : den_w;
  assign tn_sel  = tn[ax];
  assign c_mag   = tn_sel[31] ? (33'd0 - {1'b1, tn_sel}) : {1'b0, tn_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = (state != S_IDLE);
    geo_we     = 1'b0;
    geo_waddr  = AW'(vtx_index);
    geo_raddr  = AW'(corner_a);
    tan_we     = 1'b0;
    tan_waddr  = AW'(vtx_index);
    tan_wdata  = '0;
    tan_raddr  = AW'(vtx_index);
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (op_t'(operation))
            OP_LOAD: begin
              geo_we = vi_ok;
              tan_we = vi_ok;
            end
            OP_TRIANGLE: begin
              if (tri_ok) begin
                state_next = S_GEO_B;
              end
            end
            OP_READ: begin
              if (vi_ok) begin
                state_next = S_RD_DATA;
              end
            end
            default: ;
          endcase
        end
      end
      S_GEO_B: begin
        geo_raddr  = rb;
        state_next = S_GEO_C;
      end
      S_GEO_C: begin
        geo_raddr  = rc;
        state_next = S_DIFF;
      end
      S_DIFF:   state_next = S_DET_M1;
      S_DET_M1: begin
        mul_a      = du1;
        mul_b      = dv2;
        state_next = S_DET_M2;
      end
      S_DET_M2: begin
        mul_a      = du2;
        mul_b      = dv1;
        state_next = S_DET;
      end
      S_DET:    state_next = S_F_INIT;
      S_F_INIT: state_next = (det == -64'sd1) ? S_IN_M1 : S_F_DIV;
      S_F_DIV: begin
        if (dv_last) begin
          state_next = S_IN_M1;
        end
      end
      S_IN_M1: begin
        mul_a      = dv2;
        mul_b      = e1[ax];
        state_next = S_IN_M2;
      end
      S_IN_M2: begin
        mul_a      = dv1;
        mul_b      = e2[ax];
        state_next = S_IN_SUB;
      end
      S_IN_SUB: state_next = (ax == 2'd2) ? S_T_MUL : S_IN_M1;
      S_T_MUL: begin
        mul_a      = f;
        mul_b      = inner[ax];
        state_next = S_T_SAT;
      end
      S_T_SAT: state_next = (ax == 2'd2) ? S_TAN_RD : S_T_MUL;
      S_TAN_RD: begin
        tan_raddr  = corner_sel;
        state_next = S_TAN_WR;
      end
      S_TAN_WR: begin
        tan_we     = 1'b1;
        tan_waddr  = corner_sel;
        tan_wdata  = {add_sat(tan_rdata[95:64], tv[0]),
                      add_sat(tan_rdata[63:32], tv[1]),
                      add_sat(tan_rdata[31:0], tv[2])};
        state_next = (ax == 2'd2) ? S_IDLE : S_TAN_RD;
      end
      S_RD_DATA: state_next = S_SQ_X;
      S_SQ_X: begin
        mul_a      = tn[0];
        mul_b      = tn[0];
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        mul_a      = tn[1];
        mul_b      = tn[1];
        state_next = S_SQ_Z;
      end
      S_SQ_Z: begin
        mul_a      = tn[2];
        mul_b      = tn[2];
        state_next = S_SQ_SUM;
      end
      S_SQ_SUM: state_next = S_CHK;
      S_CHK:    state_next = (sos > THRESH) ? S_SQRT : S_RD_OUT;
      S_SQRT: begin
        if (sq_bit == 64'd1) begin
          state_next = S_N_INIT;
        end
      end
      S_N_INIT: state_next = S_N_DIV;
      S_N_DIV: begin
        if (dv_last) begin
          state_next = (ax == 2'd2) ? S_RD_OUT : S_N_INIT;
        end
      end
      S_RD_OUT: begin
        if (out_room) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_w;
    if (accept) begin
      vi <= vtx_index;
      ra <= AW'(corner_a);
      rb <= AW'(corner_b);
      rc <= AW'(corner_c);
    end
    case (state)
      S_GEO_B: geo_a <= geo_rdata;
      S_GEO_C: geo_b <= geo_rdata;
      S_DIFF: begin
        e1[0] <= sub_sat(geo_b[159:128], geo_a[159:128]);
        e1[1] <= sub_sat(geo_b[127:96], geo_a[127:96]);
        e1[2] <= sub_sat(geo_b[95:64], geo_a[95:64]);
        e2[0] <= sub_sat(geo_rdata[159:128], geo_a[159:128]);
        e2[1] <= sub_sat(geo_rdata[127:96], geo_a[127:96]);
        e2[2] <= sub_sat(geo_rdata[95:64], geo_a[95:64]);
        du1   <= sub_sat(geo_b[63:32], geo_a[63:32]);
        dv1   <= sub_sat(geo_b[31:0], geo_a[31:0]);
        du2   <= sub_sat(geo_rdata[63:32], geo_a[63:32]);
        dv2   <= sub_sat(geo_rdata[31:0], geo_a[31:0]);
      end
      S_DET_M2: hold <= mul_fs;
      S_DET: begin
        det <= hold - mul_fs;
        ax  <= 2'd0;
      end
      S_F_INIT: begin
        // A zero denominator saturates f to the positive limit.
        f      <= 32'sh7FFFFFFF;
        dv_num <= (64'd1 << (2 * FRAC_BITS)) << NUM_SHIFT;
        dv_den <= den_mag;
        dv_neg <= den_w[63];
        dv_rem <= '0;
        dv_q   <= '0;
        dv_cnt <= '0;
      end
      S_F_DIV, S_N_DIV: begin
        dv_num <= dv_num << 1;
        dv_rem <= dv_rem_nx;
        dv_q   <= dv_q_nx;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          if (state == S_F_DIV) begin
            f <= dv_res;
          end else begin
            nrm[ax] <= dv_res;
            ax      <= ax + 2'd1;
          end
        end
      end
      S_IN_M2: hold <= mul_fs;
      S_IN_SUB: begin
        inner[ax] <= sat32(hold - mul_fs);
        ax        <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      S_T_SAT: begin
        tv[ax] <= sat32(mul_fs);
        ax     <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      S_TAN_WR: ax <= ax + 2'd1;
      S_RD_DATA: begin
        tn[0] <= tan_rdata[95:64];
        tn[1] <= tan_rdata[63:32];
        tn[2] <= tan_rdata[31:0];
      end
      S_SQ_Y:   sos <= $unsigned(mul_p);
      S_SQ_Z:   sos <= sos + $unsigned(mul_p);
      S_SQ_SUM: sos <= sos + $unsigned(mul_p);
      S_CHK: begin
        norm_flag <= sos > THRESH;
        nrm[0]    <= tn[0];
        nrm[1]    <= tn[1];
        nrm[2]    <= tn[2];
        sq_n      <= sos;
        sq_res    <= '0;
        sq_bit    <= 64'd1 << 62;
        ax        <= 2'd0;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sq_n   <= sq_n - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_N_INIT: begin
        dv_num <= 64'(c_mag) << (FRAC_BITS + NUM_SHIFT);
        dv_den <= sq_res;
        dv_neg <= tn_sel[31];
        dv_rem <= '0;
        dv_q   <= '0;
        dv_cnt <= '0;
      end
      default: ;
    endcase
  end

  // Result register: holds a stalled word while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_RD_OUT && out_room) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD_OUT && out_room) begin
      out_vtx_index <= vi;
      tangent_x     <= nrm[0];
      tangent_y     <= nrm[1];
      tangent_z     <= nrm[2];
      normalized    <= norm_flag;
    end
  end

  // A new result only ever comes out of the final read step.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_RD_OUT)
    else $error("result appeared outside the read output step");

  // The tangent store is written only by a load or a corner update.
  a_tan_write: assert property (@(posedge clk) disable iff (rst)
    tan_we |-> (state == S_IDLE || state == S_TAN_WR))
    else $error("unexpected tangent store write");

  // The square-root probe bit stays a single bit.
  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> $onehot(sq_bit))
    else $error("square root probe bit lost");

  // A corner update follows a tangent read of the same corner.
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == S_TAN_WR |-> $past(state) == S_TAN_RD)
    else $error("corner write without preceding read");

endmodule
`default_nettype wire

// ===== test/triangle_tangent_accumulate_tb.sv =====
// Self-checking testbench for the per-vertex tangent accumulator.
`default_nettype none
module triangle_tangent_accumulate_tb;
  import tta_pkg::*;

  // Clock, reset and the handshake and data signals of both channels.
  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [1:0] operation;
  logic [9:0] vtx_index;
  logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic [9:0] corner_a, corner_b, corner_c;
  logic result_valid;
  logic result_stall;
  logic [9:0] out_vtx_index;
  logic signed [31:0] tangent_x, tangent_y, tangent_z;
  logic normalized;

  // One input word as the driver sees it.
  typedef struct {
    op_t op;
    logic [9:0] vi;
    logic signed [31:0] px, py, pz, u, v;
    logic [9:0] ca, cb, cc;
  } item_word_t;

  // One result word as the block returns it.
  typedef struct {
    logic [9:0] vi;
    logic signed [31:0] tx, ty, tz;
    logic norm;
  } tangent_word_t;

  item_word_t pending_items[$];
  tangent_word_t expected_tangents[$];

  // The predictor keeps its own copy of the vertex stores.
  logic signed [31:0] mem_px[1024], mem_py[1024], mem_pz[1024];
  logic signed [31:0] mem_u[1024], mem_v[1024];
  logic signed [31:0] mem_tx[1024], mem_ty[1024], mem_tz[1024];
  bit loaded[1024];
  int loaded_list[$];

  int errors = 0;
  bit stimulus_done = 0;
  bit hold_off = 0;
  int hold_cycles = 0;

  triangle_tangent_accumulate u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .vtx_index(vtx_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_vtx_index(out_vtx_index),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .normalized(normalized)
  );

  // The clock is 8 time units: 4 high, 4 low.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Clamps a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Truncating division clamped to 32 bits; the divisor is never zero here.
  function automatic logic signed [31:0] trunc_div(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    return clamp32(q);
  endfunction

  // Integer square root by bisection on the bit positions.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= {64'd0, n}) r = t[63:0];
    end
    return r;
  endfunction

  // Signed Q16.16 product with the fraction bits floored away.
  function automatic logic signed [127:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return p >>> 16;
  endfunction

  // Accumulates one triangle's tangent into all three corners in order.
  task automatic accumulate_triangle(input int a, input int b, input int c);
    logic signed [31:0] e1[3], e2[3], du1, dv1, du2, dv2, f, t[3];
    logic signed [127:0] det;
    logic signed [127:0] inner;
    int k[3];
    e1[0] = clamp32(128'(mem_px[b]) - 128'(mem_px[a]));
    e1[1] = clamp32(128'(mem_py[b]) - 128'(mem_py[a]));
    e1[2] = clamp32(128'(mem_pz[b]) - 128'(mem_pz[a]));
    e2[0] = clamp32(128'(mem_px[c]) - 128'(mem_px[a]));
    e2[1] = clamp32(128'(mem_py[c]) - 128'(mem_py[a]));
    e2[2] = clamp32(128'(mem_pz[c]) - 128'(mem_pz[a]));
    du1 = clamp32(128'(mem_u[b]) - 128'(mem_u[a]));
    dv1 = clamp32(128'(mem_v[b]) - 128'(mem_v[a]));
    du2 = clamp32(128'(mem_u[c]) - 128'(mem_u[a]));
    dv2 = clamp32(128'(mem_v[c]) - 128'(mem_v[a]));
    det = fmul(du1, dv2) - fmul(du2, dv1) + 1;
    // A zero denominator saturates f to the largest positive value.
    if (det == 0) f = 32'sh7FFFFFFF;
    else f = trunc_div(128'sd1 <<< 32, det);
    for (int i = 0; i < 3; i++) begin
      inner = fmul(dv2, e1[i]) - fmul(dv1, e2[i]);
      t[i] = clamp32(fmul(f, clamp32(inner)));
    end
    k[0] = a; k[1] = b; k[2] = c;
    // Repeated corners take the tangent more than once, each add saturated.
    for (int j = 0; j < 3; j++) begin
      mem_tx[k[j]] = clamp32(128'(mem_tx[k[j]]) + 128'(t[0]));
      mem_ty[k[j]] = clamp32(128'(mem_ty[k[j]]) + 128'(t[1]));
      mem_tz[k[j]] = clamp32(128'(mem_tz[k[j]]) + 128'(t[2]));
    end
  endtask

  // Works out what one accepted word does to the stores and what it returns.
  task automatic predict_word(input item_word_t w);
    tangent_word_t r;
    logic [63:0] s, len;
    case (w.op)
      OP_LOAD: begin
        mem_px[w.vi] = w.px; mem_py[w.vi] = w.py; mem_pz[w.vi] = w.pz;
        mem_u[w.vi] = w.u; mem_v[w.vi] = w.v;
        mem_tx[w.vi] = 0; mem_ty[w.vi] = 0; mem_tz[w.vi] = 0;
      end
      OP_TRIANGLE: accumulate_triangle(w.ca, w.cb, w.cc);
      OP_READ: begin
        r.vi = w.vi;
        s = 64'(128'(mem_tx[w.vi]) * 128'(mem_tx[w.vi]))
          + 64'(128'(mem_ty[w.vi]) * 128'(mem_ty[w.vi]))
          + 64'(128'(mem_tz[w.vi]) * 128'(mem_tz[w.vi]));
        // The threshold is 2^32 / 10^8 squared-length units, i.e. length 0.0001.
        r.norm = (s > 64'd42);
        if (r.norm) begin
          len = int_sqrt(s);
          r.tx = trunc_div(128'(mem_tx[w.vi]) <<< 16, 128'(len));
          r.ty = trunc_div(128'(mem_ty[w.vi]) <<< 16, 128'(len));
          r.tz = trunc_div(128'(mem_tz[w.vi]) <<< 16, 128'(len));
        end else begin
          r.tx = mem_tx[w.vi]; r.ty = mem_ty[w.vi]; r.tz = mem_tz[w.vi];
        end
        expected_tangents.insert(expected_tangents.size(), r);
      end
      default: ;
    endcase
  endtask

  // Draws a 32-bit value that often lands on an extreme or a small number.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 8)) - 4;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
    endcase
  endfunction

  // Picks a vertex that has been loaded, so no undefined entry is ever read.
  function automatic logic [9:0] pick_loaded();
    return 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // Queues a load word and tracks which vertices now hold data.
  task automatic push_load(input logic [9:0] vi, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] pz,
                           input logic signed [31:0] u, input logic signed [31:0] v);
    item_word_t w;
    w.op = OP_LOAD; w.vi = vi; w.px = px; w.py = py; w.pz = pz; w.u = u; w.v = v;
    w.ca = 10'($urandom); w.cb = 10'($urandom); w.cc = 10'($urandom);
    pending_items.insert(pending_items.size(), w);
    if (!loaded[vi]) begin
      loaded[vi] = 1;
      loaded_list.insert(loaded_list.size(), int'(vi));
    end
  endtask

  // Queues a triangle or read word; unused fields carry random noise.
  task automatic push_other(input op_t op, input logic [9:0] vi, input logic [9:0] a,
                            input logic [9:0] b, input logic [9:0] c);
    item_word_t w;
    w.op = op; w.vi = vi; w.ca = a; w.cb = b; w.cc = c;
    w.px = $urandom; w.py = $urandom; w.pz = $urandom; w.u = $urandom; w.v = $urandom;
    pending_items.insert(pending_items.size(), w);
  endtask

  task automatic drive_word(input item_word_t w);
    item_valid <= 1'b1;
    operation <= w.op; vtx_index <= w.vi;
    pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz; tex_u <= w.u; tex_v <= w.v;
    corner_a <= w.ca; corner_b <= w.cb; corner_c <= w.cc;
  endtask

  // Driver: presents one word at a time after a random gap, at the falling edge.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      // The current word goes at the coming rising edge; keep valid if the next
      // word follows with no gap so that valid is written only once here.
      void'(pending_items.pop_front());
      send_gap = $urandom_range(0, 6);
      if (pending_items.size() > 0 && send_gap == 0) begin
        drive_word(pending_items[0]);
      end else begin
        item_valid <= 1'b0;
      end
    end else if (!item_valid && pending_items.size() > 0) begin
      if (send_gap > 0) send_gap--;
      else drive_word(pending_items[0]);
    end
  end

  // Receiver stall: random per word, plus one long hold-off while words pile up.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_off) begin
      result_stall <= 1'b1;
      hold_cycles++;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (result_valid && !result_stall) begin
      // Draw how many cycles the waiting word is held off.
      stall_left = $urandom_range(0, 6);
      result_stall <= (stall_left > 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Monitor: predicts on every accepted input word and checks every accepted result.
  always @(posedge clk) begin
    tangent_word_t e;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        item_word_t w;
        w.op = op_t'(operation); w.vi = vtx_index;
        w.px = pos_x; w.py = pos_y; w.pz = pos_z; w.u = tex_u; w.v = tex_v;
        w.ca = corner_a; w.cb = corner_b; w.cc = corner_c;
        predict_word(w);
      end
      if (result_valid && !result_stall) begin
        if (expected_tangents.size() == 0) begin
          $display("%0t: unexpected result, vertex %0d", $time, out_vtx_index);
          errors++;
        end else begin
          e = expected_tangents.pop_front();
          if (out_vtx_index !== e.vi || tangent_x !== e.tx || tangent_y !== e.ty
              || tangent_z !== e.tz || normalized !== e.norm) begin
            $display("%0t: mismatch expected vi=%0d t=(%0d,%0d,%0d) n=%0d", $time,
                     e.vi, e.tx, e.ty, e.tz, e.norm);
            $display("%0t:            actual vi=%0d t=(%0d,%0d,%0d) n=%0d", $time,
                     out_vtx_index, tangent_x, tangent_y, tangent_z, normalized);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus: a directed part, then mostly well-formed meshes with some noise.
  initial begin
    logic [9:0] a;
    int r;
    item_valid = 1'b0;
    result_stall = 1'b0;
    operation = OP_LOAD; vtx_index = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; tex_u = 0; tex_v = 0;
    corner_a = 0; corner_b = 0; corner_c = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: a textbook triangle, field extremes, a zero-area UV triangle,
    // repeated corners, a short tangent and ignored operations.
    push_load(0, 0, 0, 0, 0, 0);
    push_load(1, 32'sh00010000, 0, 0, 32'sh00010000, 0);
    push_load(2, 0, 32'sh00010000, 0, 0, 32'sh00010000);
    push_other(OP_TRIANGLE, 0, 0, 1, 2);
    push_other(OP_READ, 0, 0, 0, 0);
    push_other(OP_READ, 1, 0, 0, 0);
    push_load(1023, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh7FFFFFFF);
    push_load(512, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh80000000);
    push_other(OP_TRIANGLE, 0, 1023, 512, 0);
    push_other(OP_READ, 1023, 0, 0, 0);
    push_other(OP_TRIANGLE, 0, 512, 512, 512);
    push_other(OP_READ, 512, 0, 0, 0);
    push_load(3, 5, 5, 5, 0, 0);
    push_load(4, 9, 9, 9, 0, 0);
    push_other(OP_TRIANGLE, 0, 3, 4, 0);
    push_other(OP_READ, 3, 0, 0, 0);
    push_load(5, 0, 0, 0, 0, 0);
    push_load(6, 2, 0, 0, 32'sh00000001, 32'sh00000000);
    push_load(7, 0, 3, 0, 32'sh00000000, 32'sh00000001);
    push_other(OP_TRIANGLE, 0, 5, 6, 7);
    push_other(OP_READ, 5, 0, 0, 0);
    push_other(OP_NONE, 1023, 1023, 1023, 1023);
    push_other(OP_READ, 2, 0, 0, 0);

    // Random: small meshes over a few vertices so tangents build up before reads.
    for (int n = 0; n < 680; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25 || loaded_list.size() < 3) begin
        a = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        push_load(a, pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value());
      end else if (r < 65) begin
        push_other(OP_TRIANGLE, 10'($urandom), pick_loaded(), pick_loaded(),
                   pick_loaded());
      end else if (r < 95) begin
        push_other(OP_READ, pick_loaded(), 10'($urandom), 10'($urandom),
                   10'($urandom));
      end else begin
        push_other(OP_NONE, 10'($urandom), 10'($urandom), 10'($urandom),
                   10'($urandom));
      end
      // Halfway through, stall the receiver for a long stretch so the block
      // fills up and holds its input.
      if (n == 300) begin
        while (pending_items.size() >= 300) @(posedge clk);
        hold_off = 1;
        wait (hold_cycles >= 3000);
        hold_off = 0;
      end
    end
    stimulus_done = 1;
  end

  // End of run: all words sent, all results in, then a drain for trailing work.
  initial begin
    while (!(stimulus_done && pending_items.size() == 0 && !item_valid)) @(posedge clk);
    while (expected_tangents.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_tangents.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/tta_pkg.sv
design/tta_ram.sv
design/triangle_tangent_accumulate.sv
test/triangle_tangent_accumulate_tb.sv
